// File: rtl/core/hcpd_pkg.sv
package hcpd_pkg;

    localparam int NUM_UNITS  = 16;
    localparam int MAX_UPLOAD = 9;

    localparam logic [3:0] HOME_CODE_RESET = 4'd6;

    localparam logic [3:0] FN_ON  = 4'd2;
    localparam logic [3:0] FN_OFF = 4'd3;
    localparam logic [3:0] FN_EXT = 4'd7;

    localparam logic [4:0] NO_UNIT = 5'd16;

    typedef enum logic {
        OP_BYTE   = 1'b0,
        OP_STATUS = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        start_req;
        logic [7:0]  data_byte;
        logic [15:0] known_bits;
        logic [15:0] onoff_bits;
    } t_item;

    typedef struct packed {
        logic [15:0] known_map;
        logic [15:0] on_map;
        logic        rejected;
    } t_result;

    localparam logic [3:0] CODE_TO_UNIT [16] = '{
        4'd12, 4'd4, 4'd2, 4'd10, 4'd14, 4'd6, 4'd0, 4'd8,
        4'd13, 4'd5, 4'd3, 4'd11, 4'd15, 4'd7, 4'd1, 4'd9
    };

    localparam logic [15:0] STATUS_BIT [16] = '{
        16'h4000, 16'h0040, 16'h0400, 16'h0004,
        16'h0200, 16'h0002, 16'h2000, 16'h0020,
        16'h8000, 16'h0080, 16'h0800, 16'h0008,
        16'h0100, 16'h0001, 16'h1000, 16'h0010
    };

    // Reorders a status report mask into unit order.
    function automatic logic [15:0] map_status(input logic [15:0] bits);
        logic [15:0] m;
        m = '0;
        for (int i = 0; i < NUM_UNITS; i++) begin
            m[i] = |(bits & STATUS_BIT[i]);
        end
        return m;
    endfunction

endpackage

// File: rtl/core/hcpd_in_reg.sv
module hcpd_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_advance,
    input  hcpd_pkg::t_item i_item,
    output logic           o_valid,
    output hcpd_pkg::t_item o_item
);
    import hcpd_pkg::*;

    logic  r_valid;
    t_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/core/hcpd_step.sv
module hcpd_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_data,
    input  logic              i_advance,
    input  hcpd_pkg::t_item   i_item,
    output hcpd_pkg::t_result o_result
);
    import hcpd_pkg::*;

    logic [3:0]  r_home_code;
    logic [15:0] r_known, n_known;
    logic [15:0] r_on, n_on;
    logic [3:0]  r_bytes_left, n_bytes_left;
    logic        r_mask_pending, n_mask_pending;
    logic [7:0]  r_event_mask, n_event_mask;
    logic [3:0]  r_event_index, n_event_index;
    logic [1:0]  r_skip, n_skip;
    logic [4:0]  r_sel, n_sel;
    logic        r_ignoring, n_ignoring;
    logic        rej;

    logic [15:0] stat_known;
    logic [15:0] stat_on;
    logic [3:0]  hc;
    logic [3:0]  lo;
    logic        is_func;

    assign stat_known = map_status(i_item.known_bits);
    assign stat_on    = map_status(i_item.onoff_bits);
    assign hc         = i_item.data_byte[7:4];
    assign lo         = i_item.data_byte[3:0];
    assign is_func    = !r_event_index[3] && r_event_mask[r_event_index[2:0]];

    always_comb begin
        n_known        = r_known;
        n_on           = r_on;
        n_bytes_left   = r_bytes_left;
        n_mask_pending = r_mask_pending;
        n_event_mask   = r_event_mask;
        n_event_index  = r_event_index;
        n_skip         = r_skip;
        n_sel          = r_sel;
        n_ignoring     = r_ignoring;
        rej            = 1'b0;
        priority if (i_item.op == OP_STATUS) begin
            n_known = r_known | stat_known | stat_on;
            n_on    = r_on | stat_on;
        end else if (i_item.start_req) begin
            n_event_index = '0;
            n_skip        = '0;
            n_event_mask  = '0;
            n_sel         = NO_UNIT;
            if (i_item.data_byte > 8'(MAX_UPLOAD)) begin
                rej            = 1'b1;
                n_ignoring     = 1'b1;
                n_bytes_left   = '0;
                n_mask_pending = 1'b0;
            end else begin
                n_ignoring     = 1'b0;
                n_bytes_left   = lo;
                n_mask_pending = |i_item.data_byte;
            end
        end else if (!r_ignoring && r_bytes_left != '0) begin
            n_bytes_left = r_bytes_left - 4'd1;
            priority if (r_mask_pending) begin
                n_event_mask   = i_item.data_byte;
                n_mask_pending = 1'b0;
            end else if (r_skip != '0) begin
                n_skip = r_skip - 2'd1;
            end else begin
                if (is_func) begin
                    n_skip = (lo == FN_EXT) ? 2'd2 : 2'd1;
                    if (!r_sel[4] && hc == r_home_code) begin
                        if (lo == FN_ON) begin
                            n_on[r_sel[3:0]] = 1'b1;
                        end
                        if (lo == FN_OFF) begin
                            n_on[r_sel[3:0]] = 1'b0;
                        end
                    end
                end else if (hc != r_home_code) begin
                    n_sel = NO_UNIT;
                end else begin
                    n_sel = {1'b0, CODE_TO_UNIT[lo]};
                    n_known[CODE_TO_UNIT[lo]] = 1'b1;
                end
                n_event_index = r_event_index + 4'd1;
            end
            if (n_bytes_left == '0) begin
                n_skip = '0;
            end
        end else begin
            n_bytes_left = r_bytes_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_code    <= HOME_CODE_RESET;
            r_known        <= '0;
            r_on           <= '0;
            r_bytes_left   <= '0;
            r_mask_pending <= 1'b0;
            r_event_mask   <= '0;
            r_event_index  <= '0;
            r_skip         <= '0;
            r_sel          <= NO_UNIT;
            r_ignoring     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_home_code <= i_cfg_data;
            end
            if (i_advance) begin
                r_known        <= n_known;
                r_on           <= n_on;
                r_bytes_left   <= n_bytes_left;
                r_mask_pending <= n_mask_pending;
                r_event_mask   <= n_event_mask;
                r_event_index  <= n_event_index;
                r_skip         <= n_skip;
                r_sel          <= n_sel;
                r_ignoring     <= n_ignoring;
            end
        end
    end

    assign o_result.known_map = n_known;
    assign o_result.on_map    = n_on;
    assign o_result.rejected  = rej;

`ifndef NO_ASSERTIONS
    a_on_is_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_on & ~r_known) == 16'h0000)
        else $error("A unit is on without being known.");

    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel[4] |-> (r_sel[3:0] == 4'd0))
        else $error("Selected unit is out of range.");

    a_ignore_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ignoring |-> (r_bytes_left == 4'd0 && !r_mask_pending))
        else $error("Upload still open while ignoring bytes.");

    a_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left <= 4'(MAX_UPLOAD))
        else $error("Byte count exceeds the upload limit.");

    a_known_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |=> ((r_known & $past(r_known)) == $past(r_known)))
        else $error("A known unit was lost.");
`endif

endmodule

// File: rtl/core/hcpd_out_reg.sv
module hcpd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_stall,
    input  hcpd_pkg::t_result i_result,
    output logic              o_valid,
    output hcpd_pkg::t_result o_result
);
    import hcpd_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/core/home_control_poll_decoder_unit.sv
// Poll upload decoder for a powerline home-control interface.
// Input channel: i_valid / o_stall with one item per transfer, either an
// upload byte (i_op low) or a status mask update (i_op high).
// Output channel: o_valid / i_stall; every input item yields exactly one
// result with the unit known map, the unit on map and the rejected flag.
// Configuration: i_cfg_valid / o_cfg_ready writes the house code; the
// port is always ready. Write only while the block is idle (unenforced).
// The input register feeds the decode logic, which updates the decoder
// state as it loads the result register. Unless the receiver stalls,
// one item per cycle is sustained.
// When the receiver stalls, the result register holds its item and the
// input register holds the next one; o_stall then rises and no further
// item is taken until the result is transferred.
// Synchronous reset clears both maps, the upload state and the selection,
// and restores house code 6.
module home_control_poll_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic        i_start_req,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_known_bits,
    input  logic [15:0] i_onoff_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_known_map,
    output logic [15:0] o_on_map,
    output logic        o_rejected,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    import hcpd_pkg::*;

    t_item   in_item;
    t_item   s1_item;
    t_result step_result;
    t_result out_result;
    logic    s1_valid;
    logic    advance;
    logic    load;

    assign in_item.op         = t_op'(i_op);
    assign in_item.start_req  = i_start_req;
    assign in_item.data_byte  = i_data_byte;
    assign in_item.known_bits = i_known_bits;
    assign in_item.onoff_bits = i_onoff_bits;

    assign advance     = s1_valid && !(o_valid && i_stall);
    assign o_stall     = s1_valid && !advance;
    assign load        = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    hcpd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_advance (advance),
        .i_item    (in_item),
        .o_valid   (s1_valid),
        .o_item    (s1_item)
    );

    hcpd_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_advance  (advance),
        .i_item     (s1_item),
        .o_result   (step_result)
    );

    hcpd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_stall  (i_stall),
        .i_result (step_result),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_known_map = out_result.known_map;
    assign o_on_map    = out_result.on_map;
    assign o_rejected  = out_result.rejected;

endmodule
